// ===== sv/csf_pkg.sv =====
// Shared types, sizes and codes for the clipped span fill unit.
package csf_pkg;

    localparam int ROW_BYTES   = 16;
    localparam int SCREEN_ROWS = 128;
    localparam int SCREEN_COLS = ROW_BYTES * 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int RY_W        = $clog2(SCREEN_ROWS);
    localparam int CX_W        = $clog2(SCREEN_COLS);
    localparam int BX_W        = CX_W - 3;
    localparam int CNT_W       = (RY_W > BX_W) ? RY_W : BX_W;
    localparam int CMP_W       = 18;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_VSPAN = 2'd1;
    localparam logic [1:0] REQ_HSPAN = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] CFG_MIN_X = 2'd0;
    localparam logic [1:0] CFG_MAX_X = 2'd1;
    localparam logic [1:0] CFG_MIN_Y = 2'd2;
    localparam logic [1:0] CFG_MAX_Y = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] span_first;
        logic signed [15:0] span_last;
        logic [7:0]         fill_value;
    } csf_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       nothing_drawn;
    } csf_rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_FINISH
    } csf_state_t;

    typedef enum logic [1:0] {
        MODE_COL,
        MODE_ROW,
        MODE_PIX,
        MODE_READ
    } csf_mode_t;

endpackage

// ===== sv/csf_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module csf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/clipped_span_fill_1bpp_unit.sv =====
// Top level of the clipped span fill unit for a 1-bit-per-pixel framebuffer.
//
// After reset the unit sweeps the framebuffer to zero, one byte a cycle, over
// all STORE_BYTES bytes (2048 with the default size); req_ready stays low during
// the sweep while register writes are still taken. Every request that is not
// clipped away then runs as a stream through the framebuffer RAM, one byte per
// cycle, bounded by its single write port: pixel sets and spans as
// read-modify-write, byte reads as plain reads. A request passes the idle,
// setup, run and finish states in turn; one clipped away skips the run state.
// One result beat follows each request and a finished result waits in an
// output register; a request finishing while it is still full holds in finish.
module clipped_span_fill_1bpp_unit
    import csf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  csf_req_t          req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output csf_rsp_t          rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam logic signed [CMP_W-1:0] COLS_S = CMP_W'(SCREEN_COLS);
    localparam logic signed [CMP_W-1:0] ROWS_S = CMP_W'(SCREEN_ROWS);

    csf_state_t        state_reg, state_next;
    logic [7:0]        min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              issue_reg, issue_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              rsp_valid_reg, rsp_valid_next;

    csf_req_t          req_reg;
    csf_mode_t         mode_reg, mode_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic [2:0]        lo_reg, lo_next;
    logic [2:0]        hi_reg, hi_next;
    logic [CX_W-1:0]   fx_reg, fx_next;
    logic [RY_W-1:0]   fy_reg, fy_next;
    logic [7:0]        pat_reg, pat_next;
    logic              none_reg, none_next;
    logic [7:0]        data_reg, data_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        pend_mask_reg, pend_mask_next;
    logic [7:0]        pend_bits_reg, pend_bits_next;
    csf_rsp_t          rsp_reg, rsp_next;

    logic                    cfg_wr;
    logic signed [CMP_W-1:0] x_s, y_s, first_s, last_s;
    logic signed [CMP_W-1:0] minx_s, maxx_s, miny_s, maxy_s, maxx_raw, maxy_raw;
    logic signed [CMP_W-1:0] bv_s, ev_s, bh_s, eh_s;
    logic                    on_screen, v_ok, h_ok;

    logic [RY_W-1:0]   row_idx;
    logic [BX_W-1:0]   byte_idx;
    logic [ADDR_W-1:0] acc_addr;
    logic [2:0]        hi_eff, bit_sel;
    logic [7:0]        acc_mask, acc_bits;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        case (paddr[3:2])
            CFG_MIN_X: prdata = APB_DW'(min_x_reg);
            CFG_MAX_X: prdata = APB_DW'(max_x_reg);
            CFG_MIN_Y: prdata = APB_DW'(min_y_reg);
            CFG_MAX_Y: prdata = APB_DW'(max_y_reg);
            default:   prdata = '0;
        endcase
    end

    // clip window and request geometry
    always_comb
    begin
        x_s      = {{(CMP_W-16){req_reg.coord_x[15]}}, req_reg.coord_x};
        y_s      = {{(CMP_W-16){req_reg.coord_y[15]}}, req_reg.coord_y};
        first_s  = {{(CMP_W-16){req_reg.span_first[15]}}, req_reg.span_first};
        last_s   = {{(CMP_W-16){req_reg.span_last[15]}}, req_reg.span_last};
        minx_s   = {{(CMP_W-8){1'b0}}, min_x_reg};
        miny_s   = {{(CMP_W-8){1'b0}}, min_y_reg};
        maxx_raw = {{(CMP_W-8){1'b0}}, max_x_reg};
        maxy_raw = {{(CMP_W-8){1'b0}}, max_y_reg};
        maxx_s   = (maxx_raw > COLS_S) ? COLS_S : maxx_raw;
        maxy_s   = (maxy_raw > ROWS_S) ? ROWS_S : maxy_raw;

        on_screen = (x_s >= 0) && (x_s < COLS_S) && (y_s >= 0) && (y_s < ROWS_S);
        v_ok = (maxx_s > minx_s) && (maxy_s > miny_s) && (x_s >= minx_s)
            && (x_s < maxx_s) && (first_s < maxy_s) && (last_s >= miny_s)
            && (last_s >= first_s);
        h_ok = (maxx_s > minx_s) && (maxy_s > miny_s) && (y_s >= miny_s)
            && (y_s < maxy_s) && (first_s < maxx_s) && (last_s >= minx_s)
            && (last_s >= first_s);

        bv_s = (first_s > miny_s) ? first_s : miny_s;
        ev_s = (last_s < maxy_s) ? last_s : maxy_s - CMP_W'(1);
        bh_s = (first_s > minx_s) ? first_s : minx_s;
        eh_s = (last_s < maxx_s) ? last_s : maxx_s - CMP_W'(1);
    end

    // address, mask and fill bits of the byte at the walk position
    always_comb
    begin
        row_idx  = (mode_reg == MODE_COL) ? cur_reg[RY_W-1:0] : fy_reg;
        byte_idx = (mode_reg == MODE_COL) ? fx_reg[CX_W-1:3] : cur_reg[BX_W-1:0];
        acc_addr = ADDR_W'(row_idx) * ADDR_W'(ROW_BYTES) + ADDR_W'(byte_idx);
        hi_eff   = (cur_reg == end_reg) ? hi_reg : 3'd7;
        bit_sel  = fx_reg[2:0] + cur_reg[2:0];
        case (mode_reg)
            MODE_ROW:
            begin
                acc_mask = (8'hFF << lo_reg) & (8'hFF >> (3'd7 - hi_eff));
                acc_bits = pat_reg;
            end
            MODE_COL:
            begin
                acc_mask = 8'd1 << fx_reg[2:0];
                acc_bits = {8{pat_reg[bit_sel]}};
            end
            default:
            begin
                acc_mask = 8'd1 << fx_reg[2:0];
                acc_bits = pat_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        rsp_valid_next  = rsp_valid_reg;
        mode_next       = mode_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        fx_next         = fx_reg;
        fy_next         = fy_reg;
        pat_next        = pat_reg;
        none_next       = none_reg;
        data_next       = data_reg;
        pend_addr_next  = acc_addr;
        pend_mask_next  = acc_mask;
        pend_bits_next  = acc_bits;
        rsp_next        = rsp_reg;
        req_ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = (ram_rdata & ~pend_mask_reg) | (pend_bits_reg & pend_mask_reg);
        ram_raddr       = acc_addr;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                data_next  = '0;
                issue_next = 1'b1;
                fx_next    = x_s[CX_W-1:0];
                fy_next    = y_s[RY_W-1:0];
                lo_next    = x_s[2:0];
                hi_next    = 3'd7;
                cur_next   = CNT_W'(x_s[CX_W-1:3]);
                end_next   = CNT_W'(x_s[CX_W-1:3]);
                pat_next   = (req_reg.fill_value[5:0] != 6'd0) ? 8'hFF : 8'h00;
                none_next  = 1'b1;
                state_next = ST_FINISH;
                case (req_reg.req_type)
                    REQ_PIXEL:
                    begin
                        mode_next = MODE_PIX;
                        if (on_screen)
                        begin
                            none_next  = 1'b0;
                            state_next = ST_RUN;
                        end
                    end
                    REQ_READ:
                    begin
                        mode_next = MODE_READ;
                        if (on_screen)
                        begin
                            none_next  = 1'b0;
                            state_next = ST_RUN;
                        end
                    end
                    REQ_VSPAN:
                    begin
                        mode_next = MODE_COL;
                        cur_next  = CNT_W'(bv_s[RY_W-1:0]);
                        end_next  = CNT_W'(ev_s[RY_W-1:0]);
                        pat_next  = req_reg.fill_value;
                        if (v_ok)
                        begin
                            none_next  = 1'b0;
                            state_next = ST_RUN;
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_ROW;
                        cur_next  = CNT_W'(bh_s[CX_W-1:3]);
                        end_next  = CNT_W'(eh_s[CX_W-1:3]);
                        lo_next   = bh_s[2:0];
                        hi_next   = eh_s[2:0];
                        pat_next  = req_reg.coord_y[0]
                            ? {req_reg.fill_value[0], req_reg.fill_value[7:1]}
                            : req_reg.fill_value;
                        if (h_ok)
                        begin
                            none_next  = 1'b0;
                            state_next = ST_RUN;
                        end
                    end
                endcase
            end
            ST_RUN:
            begin
                if (pend_valid_reg)
                begin
                    if (mode_reg == MODE_READ)
                    begin
                        data_next = ram_rdata;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                    end
                end
                if (issue_reg)
                begin
                    pend_valid_next = 1'b1;
                    lo_next         = 3'd0;
                    if (cur_reg == end_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = cur_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.read_data     = data_reg;
                    rsp_next.nothing_drawn = none_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            issue_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            min_x_reg      <= 8'd0;
            max_x_reg      <= 8'd128;
            min_y_reg      <= 8'd0;
            max_y_reg      <= 8'd128;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    CFG_MIN_X: min_x_reg <= pwdata[7:0];
                    CFG_MAX_X: max_x_reg <= pwdata[7:0];
                    CFG_MIN_Y: min_y_reg <= pwdata[7:0];
                    CFG_MAX_Y: max_y_reg <= pwdata[7:0];
                    default:   min_x_reg <= min_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        mode_reg      <= mode_next;
        cur_reg       <= cur_next;
        end_reg       <= end_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        fx_reg        <= fx_next;
        fy_reg        <= fy_next;
        pat_reg       <= pat_next;
        none_reg      <= none_next;
        data_reg      <= data_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        pend_bits_reg <= pend_bits_next;
        rsp_reg       <= rsp_next;
    end

    csf_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
